// ===== sv/hsvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvd_pkg
// Types, constants and helpers shared by the HSV desaturation block.
// ----------------------------------------------------------------------------
package hsvd_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int Q8_BITS      = CHANNEL_BITS + 1;  // holds 0..256
  localparam int DIV_STEPS    = 8;                 // fraction bits after the integer bit
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [Q8_BITS-1:0] ONE_Q8      = Q8_BITS'(256);
  localparam logic [Q8_BITS-1:0] SCALE_RESET = Q8_BITS'(128);
  localparam logic [11:0]        HUE_WRAP    = 12'd1536;

  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } base_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] opacity_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] opacity_out;
  } pix_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] vmax;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] mag;
    logic                    neg;
    base_e                   base;
    logic                    gray;
    logic [7:0]              opacity;
  } cls_t;

  // one restoring division step: shift in a zero, subtract when it fits
  function automatic logic [CHANNEL_BITS:0] div_step(input logic [CHANNEL_BITS-1:0] rem,
                                                      input logic [CHANNEL_BITS-1:0] dvs);
    logic [CHANNEL_BITS:0] t;
    logic [CHANNEL_BITS:0] r;
    t = {rem, 1'b0};
    if (t >= {1'b0, dvs}) begin
      r = t - {1'b0, dvs};
      return {1'b1, r[CHANNEL_BITS-1:0]};
    end
    return {1'b0, t[CHANNEL_BITS-1:0]};
  endfunction

endpackage

// ===== sv/hsvd_front.sv =====
// ----------------------------------------------------------------------------
// hsvd_front
// Classifies a pixel: max, min, delta, hue numerator and its sector base.
// ----------------------------------------------------------------------------
module hsvd_front (
  input  hsvd_pkg::pix_in_t pix_i,
  output hsvd_pkg::cls_t    cls_o
);
  import hsvd_pkg::*;

  logic [7:0] r, g, b, cmax, cmin;
  logic [7:0] na, nb;

  always_comb begin
    r = pix_i.red_in;
    g = pix_i.green_in;
    b = pix_i.blue_in;
    cmax = r;
    cmin = r;
    if (g > cmax) cmax = g;
    if (b > cmax) cmax = b;
    if (g < cmin) cmin = g;
    if (b < cmin) cmin = b;

    // ties favour red, then green
    if (r == cmax) begin
      na = g; nb = b; cls_o.base = BASE_RED;
    end else if (g == cmax) begin
      na = b; nb = r; cls_o.base = BASE_GREEN;
    end else begin
      na = r; nb = g; cls_o.base = BASE_BLUE;
    end

    cls_o.vmax    = cmax;
    cls_o.delta   = cmax - cmin;
    cls_o.gray    = (cmax == cmin);
    cls_o.neg     = (nb > na);
    cls_o.mag     = (nb > na) ? (nb - na) : (na - nb);
    cls_o.opacity = pix_i.opacity_in;
  end

endmodule

// ===== sv/hsvd_fifo.sv =====
// ----------------------------------------------------------------------------
// hsvd_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module hsvd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hsvd_pkg::cls_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output hsvd_pkg::cls_t data_o
);
  import hsvd_pkg::*;

  cls_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]     cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== sv/hsvd_back.sv =====
// ----------------------------------------------------------------------------
// hsvd_back
// Pipelined s and hue divisions, saturation scaling and p/q/t rebuild.
// ----------------------------------------------------------------------------
module hsvd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [hsvd_pkg::Q8_BITS-1:0]        scale_i,
  input  logic                                empty_i,
  input  hsvd_pkg::cls_t                      cls_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hsvd_pkg::pix_out_t                  out_pix_o
);
  import hsvd_pkg::*;

  typedef struct packed {
    cls_t                    c;
    logic [CHANNEL_BITS-1:0] s_rem;
    logic [Q8_BITS-1:0]      s_quo;
    logic [CHANNEL_BITS-1:0] f_rem;
    logic [Q8_BITS-1:0]      f_quo;
  } div_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] vmax;
    logic [7:0]              opacity;
    logic                    bypass;
    logic [Q8_BITS-1:0]      ss;
    logic [2:0]              sector;
    logic [7:0]              f;
  } hue_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] vmax;
    logic [7:0]              opacity;
    logic                    bypass;
    logic [2:0]              sector;
    logic [Q8_BITS-1:0]      kp;
    logic [Q8_BITS-1:0]      kq;
    logic [Q8_BITS-1:0]      kt;
  } fac_t;

  div_t               div_q [DIV_STEPS+1];
  logic [DIV_STEPS:0] dvld_q;
  hue_t               hue_q, hue_d;
  fac_t               fac_q, fac_d;
  logic               hvld_q, fvld_q, ovld_q;
  pix_out_t           out_q, out_d;
  div_t               div0;
  logic               adv;

  // whole pipe moves unless a finished result is held up
  assign adv         = !ovld_q || !out_stall_i;
  assign pop_o       = adv && !empty_i;
  assign out_valid_o = ovld_q;
  assign out_pix_o   = out_q;

  // integer bit of x*256/d, with x never above d
  always_comb begin
    div0.c     = cls_i;
    div0.s_quo = {{(Q8_BITS-1){1'b0}}, cls_i.delta >= cls_i.vmax};
    div0.s_rem = (cls_i.delta >= cls_i.vmax) ? '0 : cls_i.delta;
    div0.f_quo = {{(Q8_BITS-1){1'b0}}, cls_i.mag >= cls_i.delta};
    div0.f_rem = (cls_i.mag >= cls_i.delta) ? cls_i.mag - cls_i.delta : cls_i.mag;
  end

  always_ff @(posedge clk_i) begin
    logic [CHANNEL_BITS:0] ds, df;
    if (adv) begin
      div_q[0] <= div0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        ds = div_step(div_q[k-1].s_rem, div_q[k-1].c.vmax);
        df = div_step(div_q[k-1].f_rem, div_q[k-1].c.delta);
        div_q[k].c     <= div_q[k-1].c;
        div_q[k].s_quo <= {div_q[k-1].s_quo[Q8_BITS-2:0], ds[CHANNEL_BITS]};
        div_q[k].s_rem <= ds[CHANNEL_BITS-1:0];
        div_q[k].f_quo <= {div_q[k-1].f_quo[Q8_BITS-2:0], df[CHANNEL_BITS]};
        div_q[k].f_rem <= df[CHANNEL_BITS-1:0];
      end
      hue_q <= hue_d;
      fac_q <= fac_d;
      out_q <= out_d;
    end
  end

  // scaled saturation and hue position
  always_comb begin
    logic [2*Q8_BITS-1:0] prod;
    logic signed [11:0]   h;
    div_t                 e;
    e          = div_q[DIV_STEPS];
    prod       = e.s_quo * scale_i;
    hue_d.ss   = prod[Q8_BITS+7:8];
    // base code 0/1/2 stands for sector 0/2/4, i.e. 512 per step
    h          = $signed({1'b0, e.c.base, 9'h000});
    if (e.c.neg) h = h - $signed({3'b000, e.f_quo});
    else         h = h + $signed({3'b000, e.f_quo});
    if (h < 0)   h = h + $signed(HUE_WRAP);
    hue_d.sector  = h[10:8];
    hue_d.f       = h[7:0];
    hue_d.vmax    = e.c.vmax;
    hue_d.opacity = e.c.opacity;
    hue_d.bypass  = e.c.gray || (prod[Q8_BITS+7:8] == '0);
  end

  // p/q/t factors in Q1.8
  always_comb begin
    logic [2*Q8_BITS-1:0] pq, pt;
    pq = hue_q.ss * {1'b0, hue_q.f};
    pt = hue_q.ss * (ONE_Q8 - {1'b0, hue_q.f});
    fac_d.kp      = ONE_Q8 - hue_q.ss;
    fac_d.kq      = ONE_Q8 - pq[Q8_BITS+7:8];
    fac_d.kt      = ONE_Q8 - pt[Q8_BITS+7:8];
    fac_d.vmax    = hue_q.vmax;
    fac_d.opacity = hue_q.opacity;
    fac_d.bypass  = hue_q.bypass;
    fac_d.sector  = hue_q.sector;
  end

  always_comb begin
    logic [CHANNEL_BITS+Q8_BITS-1:0] mp, mq, mt;
    logic [7:0] v, p, q, t;
    v  = fac_q.vmax;
    mp = v * fac_q.kp;
    mq = v * fac_q.kq;
    mt = v * fac_q.kt;
    p  = mp[CHANNEL_BITS+7:8];
    q  = mq[CHANNEL_BITS+7:8];
    t  = mt[CHANNEL_BITS+7:8];
    out_d.opacity_out = fac_q.opacity;
    out_d.red_out   = v;
    out_d.green_out = v;
    out_d.blue_out  = v;
    if (!fac_q.bypass) begin
      case (fac_q.sector)
        3'd0: begin out_d.green_out = t; out_d.blue_out = p; end
        3'd1: begin out_d.red_out = q; out_d.blue_out = p; end
        3'd2: begin out_d.red_out = p; out_d.blue_out = t; end
        3'd3: begin out_d.red_out = p; out_d.green_out = q; end
        3'd4: begin out_d.red_out = t; out_d.green_out = p; end
        default: begin out_d.green_out = p; out_d.blue_out = q; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
      hvld_q <= 1'b0;
      fvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else if (adv) begin
      dvld_q <= {dvld_q[DIV_STEPS-1:0], pop_o};
      hvld_q <= dvld_q[DIV_STEPS];
      fvld_q <= hvld_q;
      ovld_q <= fvld_q;
    end
  end

endmodule

// ===== sv/hsv_desaturate_pixel.sv =====
// ----------------------------------------------------------------------------
// hsv_desaturate_pixel
// RGBA pixel desaturation through HSV with a programmable saturation scale.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o / in_pix_i, one request per pixel.
// Output channel: out_valid_o / out_stall_i / out_pix_o, one result per pixel.
// A request moves on an edge with valid high and stall low.
// Config: cfg_we_i writes cfg_data_i to the saturation scale (Q1.8, values
// above 256 clip to 256); write only while no pixel is in flight.
// Throughput: one pixel per clock while the output is not stalled. From the
// accepting edge a pixel passes through the queue read into 9 division
// registers, scaling, factors and the output register.
// A four-entry queue sits between the classifier and the arithmetic pipe,
// so input keeps being taken while a result waits; when the receiver stalls
// the pipe freezes and in_stall_o rises once the queue fills.
// Reset empties queue and pipe and sets the scale to one half.
// ----------------------------------------------------------------------------
module hsv_desaturate_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hsvd_pkg::pix_in_t             in_pix_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hsvd_pkg::pix_out_t            out_pix_o,
  input  logic                          cfg_we_i,
  input  logic [hsvd_pkg::Q8_BITS-1:0]  cfg_data_i
);
  import hsvd_pkg::*;

  logic [Q8_BITS-1:0] scale_q, scale_d;
  cls_t               cls_in, cls_out;
  logic               full, empty, pop;

  assign scale_d = (cfg_data_i > ONE_Q8) ? ONE_Q8 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scale_q <= SCALE_RESET;
    else if (cfg_we_i) scale_q <= scale_d;
  end

  assign in_stall_o = full;

  hsvd_front u_front (
    .pix_i (in_pix_i),
    .cls_o (cls_in)
  );

  hsvd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cls_out)
  );

  hsvd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .empty_i     (empty),
    .cls_i       (cls_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pix_o   (out_pix_o)
  );

endmodule

// ===== sv/hsvd_checker.sv =====
// ----------------------------------------------------------------------------
// hsvd_checker
// Port-level checks on the desaturation block, bound to the top level.
// ----------------------------------------------------------------------------
module hsvd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hsvd_pkg::pix_out_t out_pix_o
);

  // held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_pix_o))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // with no result waiting the pipe drains the queue, so it cannot stay full
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled although output side was free");

endmodule

bind hsv_desaturate_pixel hsvd_checker u_hsvd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_pix_o   (out_pix_o)
);

// ===== verif/tb_hsv_desaturate_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_hsv_desaturate_pixel
// Self-checking bench for the HSV desaturation block: a queued driver feeds
// pixels, a monitor compares every result against a desaturation predictor.
// ----------------------------------------------------------------------------
module tb_hsv_desaturate_pixel;
  import hsvd_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int LATENCY    = 13;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  pix_in_t              in_pix_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  pix_out_t             out_pix_o;
  logic                 cfg_we_i = 1'b0;
  logic [Q8_BITS-1:0]   cfg_data_i = '0;

  pix_in_t   pending_pix[$];
  pix_out_t  expected_pix[$];
  int        sat_scale;
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycles = 0;
  bit        calm = 1'b0;   // no idling on either side
  bit        hold = 1'b0;   // sender held off
  bit        in_taken = 1'b0;  // current request went in at the last rising edge

  hsv_desaturate_pixel i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_pix_i,
    .out_valid_o, .out_stall_i, .out_pix_o, .cfg_we_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pix_out_t desaturate(pix_in_t px, int scale);
    int r, g, b, vmax, vmin, delta, s, ss, num, base, frac, h8, sector, f;
    int p, q, t, ro, go, bo;
    pix_out_t res;
    r = px.red_in; g = px.green_in; b = px.blue_in;
    vmax = r; vmin = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    delta = vmax - vmin;
    ro = vmax; go = vmax; bo = vmax;
    if (delta != 0) begin
      s = (delta * 256) / vmax;
      ss = (s * scale) >> 8;
      if (ss != 0) begin
        if (r == vmax) begin
          num = g - b; base = 0;
        end else if (g == vmax) begin
          num = b - r; base = 2;
        end else begin
          num = r - g; base = 4;
        end
        frac = ((num < 0 ? -num : num) * 256) / delta;
        if (num < 0) frac = -frac;
        h8 = base * 256 + frac;
        if (h8 < 0) h8 += 1536;
        sector = h8 / 256;
        f = h8 % 256;
        p = (vmax * (256 - ss)) >> 8;
        q = (vmax * (256 - ((ss * f) >> 8))) >> 8;
        t = (vmax * (256 - ((ss * (256 - f)) >> 8))) >> 8;
        case (sector)
          0: begin ro = vmax; go = t; bo = p; end
          1: begin ro = q; go = vmax; bo = p; end
          2: begin ro = p; go = vmax; bo = t; end
          3: begin ro = p; go = q; bo = vmax; end
          4: begin ro = t; go = p; bo = vmax; end
          default: begin ro = vmax; go = p; bo = q; end
        endcase
      end
    end
    res.red_out = ro[7:0];
    res.green_out = go[7:0];
    res.blue_out = bo[7:0];
    res.opacity_out = px.opacity_in;
    return res;
  endfunction

  // driver: holds a request until accepted, then moves to the next one
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // keep the stalled request as it is
      end else if (pending_pix.size() > 0 && !hold &&
                   (calm || $urandom_range(99) >= 21)) begin
        in_valid_i <= 1'b1;
        in_pix_i <= pending_pix[0];
      end else begin
        in_valid_i <= 1'b0;
        in_pix_i <= pix_in_t'($urandom);
      end
      in_taken = 1'b0;
      out_stall_i <= !calm && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && !in_stall_o) begin
      expected_pix.push_back(desaturate(in_pix_i, sat_scale));
      void'(pending_pix.pop_front());
      in_taken = 1'b1;
    end
    if (out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (expected_pix.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", out_pix_o);
      end else begin
        if (out_pix_o.red_out !== expected_pix[0].red_out ||
            out_pix_o.green_out !== expected_pix[0].green_out ||
            out_pix_o.blue_out !== expected_pix[0].blue_out ||
            out_pix_o.opacity_out !== expected_pix[0].opacity_out) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h got %h", expected_pix[0], out_pix_o);
        end
        void'(expected_pix.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= MAX_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_pix.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px = pix_in_t'($urandom);
    case ($urandom_range(5))
      0: px.green_in = px.red_in;            // ties between channels
      1: begin px.green_in = px.red_in; px.blue_in = px.red_in; end
      2: px.blue_in = ($urandom_range(1)) ? 8'hff : 8'h00;
      default: ;
    endcase
    return px;
  endfunction

  task automatic drain();
    wait (pending_pix.size() == 0 && !in_valid_i);
    wait (expected_pix.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [Q8_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sat_scale = (value > 256) ? 256 : value;
  endtask

  initial begin
    logic [Q8_BITS-1:0] scales[6];
    rst_ni = 1'b0;
    scales = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd200, 9'd300};
    sat_scale = 128;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pixels at the reset scale: gray, extremes, each hue sector
    pending_pix.push_back('{8'h00, 8'h00, 8'h00, 8'h00});
    pending_pix.push_back('{8'hff, 8'hff, 8'hff, 8'hff});
    pending_pix.push_back('{8'h80, 8'h80, 8'h80, 8'h5a});
    pending_pix.push_back('{8'hff, 8'h00, 8'h00, 8'h01});
    pending_pix.push_back('{8'hff, 8'h80, 8'h00, 8'h02});
    pending_pix.push_back('{8'h80, 8'hff, 8'h00, 8'h04});
    pending_pix.push_back('{8'h00, 8'hff, 8'h80, 8'h08});
    pending_pix.push_back('{8'h00, 8'h80, 8'hff, 8'h10});
    pending_pix.push_back('{8'h80, 8'h00, 8'hff, 8'h20});
    pending_pix.push_back('{8'hff, 8'h00, 8'h80, 8'h40});
    pending_pix.push_back('{8'hff, 8'hff, 8'h00, 8'h80});
    pending_pix.push_back('{8'h00, 8'hff, 8'hff, 8'haa});
    pending_pix.push_back('{8'h02, 8'h01, 8'h01, 8'h55});  // s is one half, so ss is a quarter
    pending_pix.push_back('{8'h01, 8'h00, 8'h00, 8'hfe});
    drain();

    // scales include zero, full, clipped above range and odd values
    foreach (scales[k]) begin
      write_scale(scales[k]);
      for (int i = 0; i < 150; i++) pending_pix.push_back(rand_pixel());
      if (k == 2) begin
        calm = 1'b1;
        wait (pending_pix.size() < 75);
        calm = 1'b0;
      end
      if (k == 4) begin
        wait (pending_pix.size() < 90);
        hold = 1'b1;
        wait (expected_pix.size() == 0);
        repeat (LATENCY) @(posedge clk_i);
        hold = 1'b0;
      end
      drain();
    end

    $display("%0d results checked over seven scale settings, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
